### rtl/kdrb_pkg.sv
// ----------------------------------------------------------------------------
// kdrb_pkg
// Shared types and constants for the key debounce and report builder.
// ----------------------------------------------------------------------------
package kdrb_pkg;

  // line and key counts
  localparam int NUM_LINES  = 11;
  localparam int NUM_KEYS   = 9;
  localparam int COUNT_BITS = 8;
  localparam int THR_BITS   = 8;
  localparam int CMP_W      = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_KEYMAP_FIRST  = 2'd1,
    REG_KEYMAP_SECOND = 2'd2,
    REG_KEYMAP_LAST   = 2'd3
  } cfg_reg_t;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 8'd5;

  // request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // one key's map entry: modifier in the low byte, keycode in the high byte
  typedef logic [15:0] key_entry_t;
  typedef key_entry_t [NUM_KEYS-1:0] keymap_t;

  // one report beat
  typedef struct packed {
    logic [7:0]                  modifier_bits;
    logic [NUM_KEYS-1:0][7:0]    key_codes;
    logic                        send_flag;
    logic [NUM_LINES-1:0]        pressed_mask;
  } report_t;

endpackage

### rtl/kdrb_lane.sv
// ----------------------------------------------------------------------------
// kdrb_lane
// Debounce lane for one switch line: saturating counter and pressed flag.
// ----------------------------------------------------------------------------
module kdrb_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick_en,
  input  logic                           level,
  input  logic [kdrb_pkg::THR_BITS-1:0]  threshold,
  output logic                           pressed
);

  localparam logic [kdrb_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  logic [kdrb_pkg::COUNT_BITS-1:0] cnt_r;
  logic [kdrb_pkg::COUNT_BITS-1:0] cnt_nxt;
  logic                            pressed_r;
  logic                            pressed_nxt;
  logic                            at_thr;

  // counter reached the threshold
  assign at_thr = kdrb_pkg::CMP_W'(cnt_r) >= kdrb_pkg::CMP_W'(threshold);

  // next counter and pressed state on a tick
  always_comb begin
    cnt_nxt     = cnt_r;
    pressed_nxt = pressed_r;
    if (tick_en) begin
      if (!level) begin
        cnt_nxt     = '0;
        pressed_nxt = 1'b0;
      end else if (at_thr) begin
        pressed_nxt = 1'b1;
      end else if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + kdrb_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pressed_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  assign pressed = pressed_r;

endmodule

### rtl/kdrb_merge.sv
// ----------------------------------------------------------------------------
// kdrb_merge
// Merges the lane states into one keyboard report and tracks held keys.
// ----------------------------------------------------------------------------
module kdrb_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_en,
  input  logic [kdrb_pkg::NUM_LINES-1:0]  pressed,
  input  kdrb_pkg::keymap_t               keymap,
  output kdrb_pkg::report_t               report
);

  logic [kdrb_pkg::NUM_KEYS-1:0] held_r;
  logic [kdrb_pkg::NUM_KEYS-1:0] key_down;
  logic [7:0]                    mods;
  logic                          released;

  assign key_down = pressed[kdrb_pkg::NUM_KEYS-1:0];
  assign released = |(held_r & ~key_down);

  // modifier OR and per-key codes
  always_comb begin
    mods = '0;
    for (int k = 0; k < kdrb_pkg::NUM_KEYS; k++) begin
      if (key_down[k]) begin
        mods                = mods | keymap[k][7:0];
        report.key_codes[k] = keymap[k][15:8];
      end else begin
        report.key_codes[k] = '0;
      end
    end
    report.modifier_bits = mods;
    report.send_flag     = (|key_down) | released;
    report.pressed_mask  = pressed;
  end

  // held keys follow the pressed keys at each report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (req_en) begin
      held_r <= key_down;
    end
  end

endmodule

### rtl/kdrb_outbuf.sv
// ----------------------------------------------------------------------------
// kdrb_outbuf
// Output register with one skid entry for report beats.
// ----------------------------------------------------------------------------
module kdrb_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kdrb_pkg::report_t  push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output kdrb_pkg::report_t  out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  kdrb_pkg::report_t out_data_r;
  kdrb_pkg::report_t skid_data_r;
  logic              pop;

  assign pop = out_valid_r && !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry only fills behind a waiting beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output beat");

  // a stalled beat with a full skid keeps the skid entry
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> skid_valid_r)
    else $error("skid entry lost under stall");

  // a push into an empty buffer shows up next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("pushed beat did not land in output register");

  // no beat appears without a push
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !out_valid_r) |=> !out_valid_r)
    else $error("output beat without push");

endmodule

### rtl/key_debounce_report_builder.sv
// ----------------------------------------------------------------------------
// key_debounce_report_builder
// Debounces eleven switch lines and builds keyboard reports on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_req_type 0 is a debounce tick
//   that updates all eleven lanes from in_raw_levels and gives no beat;
//   in_req_type 1 is a report request that gives one beat on the output
//   channel (out_valid / out_stall).
//   Throughput is one input beat per cycle while in_stall is low. Eleven
//   debounce lanes update in parallel, and the report merge is one level of
//   OR/select. The output register is backed by one skid entry: in_stall
//   rises only when both hold beats, that is after two reports meet a
//   stalled receiver. Configuration (cfg_wr_en / cfg_index / cfg_wdata)
//   writes the threshold and key maps; the user must do so only while the
//   block is idle, which the block does not enforce. Unknown indexes are
//   not possible with the two-bit index, all four are registers.
//   Reset clears counters, pressed and held state, empties the output
//   buffer, sets the threshold to 5 and the key maps to 0.
// ----------------------------------------------------------------------------
module key_debounce_report_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [kdrb_pkg::NUM_LINES-1:0]   in_raw_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_modifier_bits,
  output logic [7:0]                       out_key1_code,
  output logic [7:0]                       out_key2_code,
  output logic [7:0]                       out_key3_code,
  output logic [7:0]                       out_key4_code,
  output logic [7:0]                       out_key5_code,
  output logic [7:0]                       out_key6_code,
  output logic [7:0]                       out_key7_code,
  output logic [7:0]                       out_key8_code,
  output logic [7:0]                       out_key9_code,
  output logic                             out_send_flag,
  output logic [kdrb_pkg::NUM_LINES-1:0]   out_pressed_mask,
  input  logic                             cfg_wr_en,
  input  logic [kdrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdrb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [kdrb_pkg::THR_BITS-1:0] thr_r;
  logic [63:0]                   keymap_first_r;
  logic [63:0]                   keymap_second_r;
  logic [15:0]                   keymap_last_r;
  kdrb_pkg::keymap_t             keymap;
  logic                          in_accept;
  logic                          tick_en;
  logic                          req_en;
  logic                          buf_full;
  logic [kdrb_pkg::NUM_LINES-1:0] pressed;
  kdrb_pkg::report_t             report;
  kdrb_pkg::report_t             out_data;

  assign in_accept = in_valid && !in_stall;
  assign tick_en   = in_accept && (in_req_type == kdrb_pkg::REQ_TICK);
  assign req_en    = in_accept && (in_req_type == kdrb_pkg::REQ_REPORT);
  assign in_stall  = buf_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r           <= kdrb_pkg::THRESHOLD_RESET;
      keymap_first_r  <= '0;
      keymap_second_r <= '0;
      keymap_last_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (kdrb_pkg::cfg_reg_t'(cfg_index))
        kdrb_pkg::REG_THRESHOLD:     thr_r           <= cfg_wdata[kdrb_pkg::THR_BITS-1:0];
        kdrb_pkg::REG_KEYMAP_FIRST:  keymap_first_r  <= cfg_wdata;
        kdrb_pkg::REG_KEYMAP_SECOND: keymap_second_r <= cfg_wdata;
        kdrb_pkg::REG_KEYMAP_LAST:   keymap_last_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // unpack key map entries
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      keymap[k]     = keymap_first_r[16*k +: 16];
      keymap[k + 4] = keymap_second_r[16*k +: 16];
    end
    keymap[8] = keymap_last_r;
  end

  // debounce lanes
  for (genvar g = 0; g < kdrb_pkg::NUM_LINES; g++) begin : g_lane
    kdrb_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .tick_en   (tick_en),
      .level     (in_raw_levels[g]),
      .threshold (thr_r),
      .pressed   (pressed[g])
    );
  end

  // report merge
  kdrb_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_en (req_en),
    .pressed(pressed),
    .keymap (keymap),
    .report (report)
  );

  // output buffer
  kdrb_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_en),
    .push_data (report),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_modifier_bits = out_data.modifier_bits;
  assign out_key1_code     = out_data.key_codes[0];
  assign out_key2_code     = out_data.key_codes[1];
  assign out_key3_code     = out_data.key_codes[2];
  assign out_key4_code     = out_data.key_codes[3];
  assign out_key5_code     = out_data.key_codes[4];
  assign out_key6_code     = out_data.key_codes[5];
  assign out_key7_code     = out_data.key_codes[6];
  assign out_key8_code     = out_data.key_codes[7];
  assign out_key9_code     = out_data.key_codes[8];
  assign out_send_flag     = out_data.send_flag;
  assign out_pressed_mask  = out_data.pressed_mask;

  // a tick into an empty output never makes a beat
  a_tick_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && !out_valid) |=> !out_valid)
    else $error("tick produced an output beat");

  // line 0 reads released after a tick with its level low
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && !in_raw_levels[0]) |=> !pressed[0])
    else $error("line 0 still pressed after low tick");

  // pressed keys drive the send flag of the report being built
  a_send_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    (|pressed[kdrb_pkg::NUM_KEYS-1:0]) |-> report.send_flag)
    else $error("send flag low with keys pressed");

endmodule
